>>> rtl/srgb_transfer_convert_assert.svh
// Assertion macros for the sRGB transfer converter.
`ifndef SRGB_TRANSFER_CONVERT_ASSERT_SVH
`define SRGB_TRANSFER_CONVERT_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define SRGB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("srgb_transfer_convert: assertion failed");
// Check that a condition implies another one on the next edge.
`define SRGB_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("srgb_transfer_convert: assertion failed");
`else
`define SRGB_ASSERT(lbl, prop)
`define SRGB_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> rtl/srgb_tc_pkg.sv
// Package with constants, op codes and table generation for the sRGB converter.
`default_nettype none

package srgb_tc_pkg;

    localparam int PORT_BITS           = 16;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int TABLE_ADDR_BITS_DEF = 8;

    typedef enum logic {
        OP_DECODE = 1'b0,
        OP_ENCODE = 1'b1
    } op_t;

    localparam longint unsigned Q_ONE   = 64'd1 << 31;
    localparam longint unsigned CLAMP32 = 64'hFFFF_FFFF;

    // Unsigned Q31 power by repeated truncated products, clamped to 32 bits.
    function automatic longint unsigned q_pow(input longint unsigned t, input int unsigned n);
        longint unsigned p;
        p = t;
        for (int unsigned i = 1; i < n; i++) begin
            p = (p * t) >> 31;
            if (p > CLAMP32) begin
                p = CLAMP32;
            end
        end
        return p;
    endfunction

    // Largest 32-bit Q31 value r with r^n <= v.
    function automatic longint unsigned q_root(input longint unsigned v, input int unsigned n);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (q_pow(t, n) <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    // Restoring shift-subtract division, used only while building tables.
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        logic [64:0]     rem;
        longint unsigned quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // One power-segment sample k of the decode or encode table.
    function automatic logic [31:0] rom_sample(input logic enc, input int unsigned k,
                                               input int unsigned sb, input int unsigned ab);
        int unsigned     a;
        int unsigned     f;
        longint unsigned maxv;
        longint unsigned code;
        longint unsigned x;
        longint unsigned v;
        longint unsigned w;
        longint unsigned q;
        longint unsigned s;
        a    = (ab < sb) ? ab : sb;
        f    = sb - a;
        maxv = (64'd1 << sb) - 64'd1;
        code = longint'(k) << f;
        x    = div_u64((code << 31) + (maxv >> 1), maxv);
        if (!enc) begin
            v = (64'd1000 * x + 64'd55 * Q_ONE) / 64'd1055;
            q = q_pow(q_root(v, 5), 12);
        end else begin
            w = q_pow(q_root(x, 12), 5);
            q = 0;
            if (64'd1055 * w > 64'd55 * Q_ONE) begin
                q = (64'd1055 * w - 64'd55 * Q_ONE) / 64'd1000;
            end
        end
        s = (q * maxv + (Q_ONE >> 1)) >> 31;
        if (s > maxv) begin
            s = maxv;
        end
        return s[31:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/srgb_transfer_convert.sv
// Top level of the sRGB transfer converter: four-stage stallable pipeline.
//
// Usage:
//   Input channel: sample_valid / sample_stall carry op and sample_in. A
//   transfer happens on a rising edge with sample_valid high and
//   sample_stall low. op = decode turns an sRGB code into linear light,
//   op = encode turns linear light into an sRGB code.
//   Output channel: result_valid / result_stall carry sample_out, one
//   result per accepted item, in order.
//   Each accepted item passes four register stages in order: table read,
//   difference and product, reciprocal multiply and interpolation sum,
//   correction and saturation.
//   Throughput: one item per clock while the receiver does not stall;
//   every stage takes a new item each cycle unless the stage after it is held.
//   The power segment reads one sample pair from a constant table split in
//   even and odd banks, so both neighbors come out in the same cycle.
//   Reset (rst_n low, asynchronous) empties the pipeline; the tables are
//   constant and need no fill, so items are taken right after reset.
//   When the receiver stalls, the output register holds its transfer and
//   each stage holds while the stage after it is full and held; bubbles
//   still close up, so sample_stall rises only once every stage is full.
`default_nettype none

module srgb_transfer_convert #(
    parameter int SAMPLE_BITS     = srgb_tc_pkg::SAMPLE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = srgb_tc_pkg::TABLE_ADDR_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              sample_valid,
    output      logic                              sample_stall,
    input  wire logic                              op,
    input  wire logic [srgb_tc_pkg::PORT_BITS-1:0] sample_in,
    output      logic                              result_valid,
    input  wire logic                              result_stall,
    output      logic [srgb_tc_pkg::PORT_BITS-1:0] sample_out
);

`include "srgb_transfer_convert_assert.svh"

    // Table geometry: A index bits, F interpolation fraction bits.
    localparam int A        = (TABLE_ADDR_BITS < SAMPLE_BITS) ? TABLE_ADDR_BITS : SAMPLE_BITS;
    localparam int F        = SAMPLE_BITS - A;
    localparam int FW       = (F > 0) ? F : 1;
    localparam int HALF_LEN = 2 ** (A - 1);
    localparam int PW       = SAMPLE_BITS + FW;
    // Linear-segment numerators stay below 2^NW (about 4.05 * full scale).
    localparam int NW       = SAMPLE_BITS + 4;
    localparam int CW       = 11;

    localparam longint unsigned MAXV_L      = (64'd1 << SAMPLE_BITS) - 64'd1;
    localparam logic [SAMPLE_BITS-1:0] MAXV = '1;
    localparam longint unsigned DEC_LIN_L   = (64'd4045 * MAXV_L) / 64'd100000;
    localparam longint unsigned ENC_LIN_L   = (64'd31308 * MAXV_L) / 64'd10000000;
    localparam logic [SAMPLE_BITS-1:0] DEC_LIN_MAX = SAMPLE_BITS'(DEC_LIN_L);
    localparam logic [SAMPLE_BITS-1:0] ENC_LIN_MAX = SAMPLE_BITS'(ENC_LIN_L);

    localparam logic [FW-1:0] FRAC_MASK = FW'((2 ** F) - 1);
    localparam logic [PW:0]   ROUND     = (PW + 1)'((2 ** F) / 2);

    // Divisors of the linear segments and their reciprocals at 2^-NW.
    localparam logic [CW-1:0] DIV_DEC = CW'(1292);
    localparam logic [CW-1:0] DIV_ENC = CW'(100);
    localparam logic [NW-1:0] REC_DEC = NW'((64'd1 << NW) / 64'd1292);
    localparam logic [NW-1:0] REC_ENC = NW'((64'd1 << NW) / 64'd100);

    // Constant power-segment tables, even and odd samples in separate banks.
    logic [SAMPLE_BITS-1:0] even_tab [2][HALF_LEN+1];
    logic [SAMPLE_BITS-1:0] odd_tab  [2][HALF_LEN];

    for (genvar j = 0; j <= HALF_LEN; j++) begin : g_even
        localparam logic [SAMPLE_BITS-1:0] DEC_E = SAMPLE_BITS'(srgb_tc_pkg::rom_sample(
            1'b0, 2 * j, SAMPLE_BITS, TABLE_ADDR_BITS));
        localparam logic [SAMPLE_BITS-1:0] ENC_E = SAMPLE_BITS'(srgb_tc_pkg::rom_sample(
            1'b1, 2 * j, SAMPLE_BITS, TABLE_ADDR_BITS));
        assign even_tab[0][j] = DEC_E;
        assign even_tab[1][j] = ENC_E;
    end

    for (genvar j = 0; j < HALF_LEN; j++) begin : g_odd
        localparam logic [SAMPLE_BITS-1:0] DEC_O = SAMPLE_BITS'(srgb_tc_pkg::rom_sample(
            1'b0, 2 * j + 1, SAMPLE_BITS, TABLE_ADDR_BITS));
        localparam logic [SAMPLE_BITS-1:0] ENC_O = SAMPLE_BITS'(srgb_tc_pkg::rom_sample(
            1'b1, 2 * j + 1, SAMPLE_BITS, TABLE_ADDR_BITS));
        assign odd_tab[0][j] = DEC_O;
        assign odd_tab[1][j] = ENC_O;
    end

    // ------------------------------------------------------------------
    // Handshake: a stage advances when it is empty or the next one moves.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready;

    assign s4_ready     = !s4_valid_reg || !result_stall;
    assign s3_ready     = !s3_valid_reg || s4_ready;
    assign s2_ready     = !s2_valid_reg || s3_ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign sample_stall = !s1_ready;
    assign result_valid = s4_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= sample_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: segment select and table pair read.
    // ------------------------------------------------------------------
    srgb_tc_pkg::op_t       op_in;
    logic [SAMPLE_BITS-1:0] x_in;
    logic [A-1:0]           idx;
    logic [A-1:0]           even_addr;
    logic [A-2:0]           odd_addr;
    logic [SAMPLE_BITS-1:0] even_val;
    logic [SAMPLE_BITS-1:0] odd_val;
    logic                   s1_lin_next;
    logic [SAMPLE_BITS-1:0] s1_lo_next;
    logic [SAMPLE_BITS-1:0] s1_hi_next;

    srgb_tc_pkg::op_t       s1_op_reg;
    logic                   s1_lin_reg;
    logic [SAMPLE_BITS-1:0] s1_x_reg;
    logic [SAMPLE_BITS-1:0] s1_lo_reg;
    logic [SAMPLE_BITS-1:0] s1_hi_reg;

    assign op_in     = srgb_tc_pkg::op_t'(op);
    assign x_in      = SAMPLE_BITS'(sample_in);
    assign idx       = x_in[SAMPLE_BITS-1 -: A];
    // An even index takes its low sample from the even bank, an odd one
    // from the odd bank; the high neighbor comes from the other bank.
    assign even_addr = A'(idx[A-1:1]) + A'(idx[0]);
    assign odd_addr  = idx[A-1:1];
    assign even_val  = even_tab[op_in][even_addr];
    assign odd_val   = odd_tab[op_in][odd_addr];

    always_comb
    begin
        if (op_in == srgb_tc_pkg::OP_ENCODE)
        begin
            s1_lin_next = (x_in <= ENC_LIN_MAX);
        end
        else
        begin
            s1_lin_next = (x_in <= DEC_LIN_MAX);
        end
        if (idx[0])
        begin
            s1_lo_next = odd_val;
            s1_hi_next = even_val;
        end
        else
        begin
            s1_lo_next = even_val;
            s1_hi_next = odd_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_op_reg  <= op_in;
            s1_lin_reg <= s1_lin_next;
            s1_x_reg   <= x_in;
            s1_lo_reg  <= s1_lo_next;
            s1_hi_reg  <= s1_hi_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: neighbor difference times fraction; linear numerator.
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] diff;
    logic [FW-1:0]          frac;
    logic [PW-1:0]          s2_prod_next;
    logic [NW-1:0]          s1_x_ext;
    logic [NW-1:0]          s2_numer_next;

    srgb_tc_pkg::op_t       s2_op_reg;
    logic                   s2_lin_reg;
    logic [SAMPLE_BITS-1:0] s2_lo_reg;
    logic [PW-1:0]          s2_prod_reg;
    logic [NW-1:0]          s2_numer_reg;

    assign diff         = (s1_hi_reg > s1_lo_reg) ? (s1_hi_reg - s1_lo_reg) : '0;
    assign frac         = FW'(s1_x_reg) & FRAC_MASK;
    assign s2_prod_next = PW'(diff) * PW'(frac);
    assign s1_x_ext     = NW'(s1_x_reg);

    always_comb
    begin
        if (s1_op_reg == srgb_tc_pkg::OP_ENCODE)
        begin
            s2_numer_next = NW'(s1_x_ext * NW'(DIV_DEC) + NW'(50));
        end
        else
        begin
            s2_numer_next = NW'(s1_x_ext * NW'(100) + NW'(646));
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_op_reg    <= s1_op_reg;
            s2_lin_reg   <= s1_lin_reg;
            s2_lo_reg    <= s1_lo_reg;
            s2_prod_reg  <= s2_prod_next;
            s2_numer_reg <= s2_numer_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: quotient estimate by reciprocal; rounded interpolation sum.
    // ------------------------------------------------------------------
    logic [NW-1:0]          recip;
    logic [2*NW-1:0]        qprod;
    logic [NW-1:0]          s3_qest_next;
    logic [PW:0]            prod_rnd;
    logic [SAMPLE_BITS:0]   s3_interp_next;

    srgb_tc_pkg::op_t       s3_op_reg;
    logic                   s3_lin_reg;
    logic [NW-1:0]          s3_numer_reg;
    logic [NW-1:0]          s3_qest_reg;
    logic [SAMPLE_BITS:0]   s3_interp_reg;

    assign recip          = (s2_op_reg == srgb_tc_pkg::OP_ENCODE) ? REC_ENC : REC_DEC;
    assign qprod          = (2 * NW)'(s2_numer_reg) * (2 * NW)'(recip);
    assign s3_qest_next   = qprod[2*NW-1:NW];
    assign prod_rnd       = (PW + 1)'(s2_prod_reg) + ROUND;
    assign s3_interp_next = (SAMPLE_BITS + 1)'(s2_lo_reg)
                          + (SAMPLE_BITS + 1)'(prod_rnd >> F);

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_op_reg     <= s2_op_reg;
            s3_lin_reg    <= s2_lin_reg;
            s3_numer_reg  <= s2_numer_reg;
            s3_qest_reg   <= s3_qest_next;
            s3_interp_reg <= s3_interp_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: quotient correction, segment select, saturation.
    // ------------------------------------------------------------------
    logic [CW-1:0]          cdiv;
    logic [NW-1:0]          rem;
    logic [NW-1:0]          quot;
    logic [NW-1:0]          y;
    logic [SAMPLE_BITS-1:0] s4_sample_next;
    logic [SAMPLE_BITS-1:0] s4_sample_reg;

    assign cdiv = (s3_op_reg == srgb_tc_pkg::OP_ENCODE) ? DIV_ENC : DIV_DEC;
    assign rem  = s3_numer_reg - NW'(s3_qest_reg * NW'(cdiv));
    // The estimate is at most one short of the true quotient.
    assign quot = (rem >= NW'(cdiv)) ? (s3_qest_reg + NW'(1)) : s3_qest_reg;
    assign y    = s3_lin_reg ? quot : NW'(s3_interp_reg);
    assign s4_sample_next = (y > NW'(MAXV)) ? MAXV : y[SAMPLE_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (s4_ready)
        begin
            s4_sample_reg <= s4_sample_next;
        end
    end

    assign sample_out = srgb_tc_pkg::PORT_BITS'(s4_sample_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A stage that cannot pass its item on keeps it.
    `SRGB_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s2_ready, s1_valid_reg)
    // The reciprocal estimate leaves less than two divisors of remainder.
    `SRGB_ASSERT(a_rem_range, s3_valid_reg && s3_lin_reg |-> rem < (NW'(cdiv) << 1))
    // Interpolation between monotone samples never passes full scale.
    `SRGB_ASSERT(a_interp_top, s3_valid_reg && !s3_lin_reg |-> s3_interp_reg <= {1'b0, MAXV})

endmodule

`default_nettype wire

>>> tb/sv/srgb_tc_tb_pkg.sv
// Scoreboard for the sRGB converter bench: its own curve tables and in-order expected codes.
package srgb_tc_tb_pkg;

    import srgb_tc_pkg::*;

    localparam int CODE_BITS = SAMPLE_BITS_DEF;
    localparam int SEG_BITS  = (TABLE_ADDR_BITS_DEF < CODE_BITS) ? TABLE_ADDR_BITS_DEF
                                                                  : CODE_BITS;
    localparam int FINE_BITS = CODE_BITS - SEG_BITS;
    localparam int CURVE_LEN = (1 << SEG_BITS) + 1;
    localparam longint unsigned CODE_MAX = (64'd1 << CODE_BITS) - 64'd1;
    localparam longint unsigned UNITY    = 64'd1 << 31;
    localparam longint unsigned SAT32    = 64'hFFFF_FFFF;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct packed {
        op_t                  dir;
        logic [PORT_BITS-1:0] code;
        logic [PORT_BITS-1:0] want;
    } outstanding_t;

    class srgb_code_tracker;

        longint unsigned decode_curve [CURVE_LEN];
        longint unsigned encode_curve [CURVE_LEN];
        outstanding_t    outstanding [$];
        int unsigned     mismatches;

        function new();
            longint unsigned x;
            longint unsigned v;
            longint unsigned w;
            longint unsigned h;
            mismatches = 0;
            for (int k = 0; k < CURVE_LEN; k++) begin
                // fraction of the knot code in Q31, rounded to nearest
                x = (((longint'(k) << FINE_BITS) << 31) + (CODE_MAX >> 1)) / CODE_MAX;
                v = (64'd1000 * x + 64'd55 * UNITY) / 64'd1055;
                decode_curve[k] = to_code(fix_power(fix_root(v, 5), 12));
                w = fix_power(fix_root(x, 12), 5);
                h = 0;
                if (64'd1055 * w > 64'd55 * UNITY) begin
                    h = (64'd1055 * w - 64'd55 * UNITY) / 64'd1000;
                end
                encode_curve[k] = to_code(h);
            end
        endfunction

        // truncated Q31 product chain, capped at 32 bits after every step
        function longint unsigned fix_power(longint unsigned base, int unsigned n);
            longint unsigned acc;
            acc = base;
            repeat (n - 1) begin
                acc = (acc * base) >> 31;
                if (acc > SAT32) begin
                    acc = SAT32;
                end
            end
            return acc;
        endfunction

        // largest Q31 root whose n-th power stays at or below v
        function longint unsigned fix_root(longint unsigned v, int unsigned n);
            longint unsigned r;
            longint unsigned trial;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = r | (64'd1 << b);
                if (fix_power(trial, n) <= v) begin
                    r = trial;
                end
            end
            return r;
        endfunction

        function longint unsigned to_code(longint unsigned q);
            longint unsigned s;
            s = (q * CODE_MAX + (UNITY >> 1)) >> 31;
            return (s > CODE_MAX) ? CODE_MAX : s;
        endfunction

        function longint unsigned interpolate(bit enc, longint unsigned x);
            longint unsigned idx;
            longint unsigned frac;
            longint unsigned half;
            longint unsigned lo;
            longint unsigned hi;
            longint unsigned d;
            longint unsigned y;
            idx  = x >> FINE_BITS;
            frac = x & ((64'd1 << FINE_BITS) - 64'd1);
            half = (FINE_BITS > 0) ? ((64'd1 << FINE_BITS) >> 1) : 64'd0;
            if (idx > CURVE_LEN - 2) begin
                idx = CURVE_LEN - 2;
            end
            lo = enc ? encode_curve[idx] : decode_curve[idx];
            hi = enc ? encode_curve[idx + 1] : decode_curve[idx + 1];
            d  = (hi > lo) ? hi - lo : 64'd0;
            y  = lo + ((d * frac + half) >> FINE_BITS);
            return (y > CODE_MAX) ? CODE_MAX : y;
        endfunction

        function logic [PORT_BITS-1:0] convert_code(op_t dir, logic [PORT_BITS-1:0] code);
            longint unsigned x;
            longint unsigned y;
            x = longint'(code) & CODE_MAX;
            if (dir == OP_DECODE) begin
                // straight segment up to 0.04045, then the curve
                if (x * 64'd100000 <= 64'd4045 * CODE_MAX) begin
                    y = (x * 64'd100 + 64'd646) / 64'd1292;
                end else begin
                    y = interpolate(1'b0, x);
                end
            end else begin
                // straight segment up to 0.0031308, then the curve
                if (x * 64'd10000000 <= 64'd31308 * CODE_MAX) begin
                    y = (x * 64'd1292 + 64'd50) / 64'd100;
                end else begin
                    y = interpolate(1'b1, x);
                end
            end
            if (y > CODE_MAX) begin
                y = CODE_MAX;
            end
            return y[PORT_BITS-1:0];
        endfunction

        function void note_input(op_t dir, logic [PORT_BITS-1:0] code);
            outstanding_t item;
            item.dir  = dir;
            item.code = code;
            item.want = convert_code(dir, code);
            outstanding.push_back(item);
        endfunction

        function void check_result(logic [PORT_BITS-1:0] got);
            outstanding_t head;
            if (outstanding.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected result %0d with nothing outstanding", got);
                end
                return;
            end
            head = outstanding.pop_front();
            if (got !== head.want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("mismatch: %s of %0d: expected %0d, got %0d",
                             (head.dir == OP_DECODE) ? "decode" : "encode",
                             head.code, head.want, got);
                end
            end
        endfunction

        function int unsigned waiting();
            return outstanding.size();
        endfunction

    endclass

endpackage

>>> tb/sv/tb_srgb_transfer_convert.sv
// Top of the sRGB converter bench: drives both channels with random idling and checks each result.
module tb_srgb_transfer_convert;

    timeunit 1ns;
    timeprecision 1ps;

    import srgb_tc_pkg::*;
    import srgb_tc_tb_pkg::*;

    // Codes around both knees, the table seams and both ends of the scale.
    localparam logic [PORT_BITS-1:0] CORNER_CODES [0:11] = '{
        16'd0, 16'd1, 16'd205, 16'd206, 16'd255, 16'd256,
        16'd2650, 16'd2651, 16'd32768, 16'd65280, 16'd65534, 16'd65535
    };

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    logic                 op           = 1'b0;
    logic [PORT_BITS-1:0] sample_in    = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [PORT_BITS-1:0] sample_out;

    // Odds (percent) of an idle burst before a transfer and of a stall burst per cycle.
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;

    srgb_code_tracker tracker;

    srgb_transfer_convert i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .op           (op),
        .sample_in    (sample_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sample_out   (sample_out)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Watch both channels at the edge. Everything read here still holds the value from
    // before this edge, so a transfer is seen exactly when the block sees it.
    always @(posedge clk) begin
        if (rst_n) begin
            if (sample_valid && !sample_stall) begin
                tracker.note_input(op_t'(op), sample_in);
            end
            if (result_valid && !result_stall) begin
                tracker.check_result(sample_out);
            end
        end
    end

    // Receiver: hold off the output in bursts, as often as stall_pct asks.
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && $urandom_range(0, 99) < stall_pct) begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Offer one transfer and return at the edge that takes it. An idle burst, when drawn,
    // drops valid and puts junk on the payload first. Valid stays high from one transfer
    // to the next when no burst comes, so it is never lowered and raised in one step.
    task automatic send_sample(op_t dir, logic [PORT_BITS-1:0] code);
        if ($urandom_range(0, 99) < gap_pct) begin
            sample_valid <= 1'b0;
            op           <= 1'($urandom);
            sample_in    <= PORT_BITS'($urandom);
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        op           <= dir;
        sample_in    <= code;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
    endtask

    // Random transfers, weighted toward the knees and both ends of the scale.
    task automatic random_stretch(int unsigned count, int unsigned gaps, int unsigned stalls);
        int unsigned          pick;
        logic [PORT_BITS-1:0] code;
        gap_pct   = gaps;
        stall_pct = stalls;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                code = PORT_BITS'($urandom);
            end else if (pick < 65) begin
                code = PORT_BITS'($urandom_range(2600, 2700));    // decode knee
            end else if (pick < 80) begin
                code = PORT_BITS'($urandom_range(150, 260));      // encode knee
            end else if (pick < 90) begin
                code = PORT_BITS'($urandom_range(0, 1023));
            end else begin
                code = PORT_BITS'($urandom_range(64512, 65535));  // near full scale
            end
            send_sample(op_t'($urandom_range(0, 1)), code);
        end
    endtask

    initial begin : main_seq
        tracker   = new();
        gap_pct   = 20;
        stall_pct = 15;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner codes in both directions.
        foreach (CORNER_CODES[i]) begin
            send_sample(OP_DECODE, CORNER_CODES[i]);
            send_sample(OP_ENCODE, CORNER_CODES[i]);
        end

        // Mixed idling, a clean stretch, heavy idling, then a clean finish.
        random_stretch(500, 25, 20);
        random_stretch(200, 0, 0);
        random_stretch(400, 60, 50);
        random_stretch(200, 0, 0);
        sample_valid <= 1'b0;

        // Drain, then keep the clock running with no input so that any extra result still shows.
        while (tracker.waiting() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.waiting() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/srgb_tc_pkg.sv
rtl/srgb_transfer_convert.sv
tb/sv/srgb_tc_tb_pkg.sv
tb/sv/tb_srgb_transfer_convert.sv
